// ===== sv/rvm_pkg.sv =====
package rvm_pkg;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } out_t;

  // squares, cross products and raw components handed from the front to the back through the queue
  typedef struct packed {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    logic [63:0]        sq0;
    logic [63:0]        sq1;
    logic [63:0]        sq2;
    logic signed [63:0] p01;
    logic signed [63:0] p02;
    logic signed [63:0] p12;
  } qe_t;

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  // pi/4 in q.28, 2*pi and 4*pi for the range reduction, and the octant boundaries
  localparam logic [27:0] P4 = 28'd210828714;
  localparam logic [31:0] M1 = 32'd1686629712;
  localparam logic [31:0] M2 = 32'd3373259424;

  localparam logic [30:0] OCT_BASE [8] = '{
    31'd0, 31'd210828714, 31'd421657428, 31'd632486142,
    31'd843314856, 31'd1054143570, 31'd1264972284, 31'd1475800998
  };

  // taylor coefficients, q.34, index is the power of t
  localparam logic [34:0] SIN_C [7] = '{
    35'd17179869184, 35'd2863311531, 35'd143165577, 35'd3408704,
    35'd47343, 35'd430, 35'd3
  };
  localparam logic [34:0] OMC_C [7] = '{
    35'd8589934592, 35'd715827883, 35'd23860929, 35'd426088,
    35'd4734, 35'd36, 35'd0
  };

endpackage

// ===== sv/rvm_front.sv =====
module rvm_front
  import rvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  vec,
  output logic q_push,
  input  logic q_full,
  output qe_t  q_data
);

  logic fv;
  in_t  fw;

  assign full   = fv && q_full;
  assign q_push = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (push && !full) begin
      fv <= 1'b1;
    end else if (!q_full) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      fw <= vec;
    end
  end

  // squares and cross products, one multiplier per term
  always_comb begin
    q_data.w0  = fw.rot_x;
    q_data.w1  = fw.rot_y;
    q_data.w2  = fw.rot_z;
    q_data.sq0 = fw.rot_x * fw.rot_x;
    q_data.sq1 = fw.rot_y * fw.rot_y;
    q_data.sq2 = fw.rot_z * fw.rot_z;
    q_data.p01 = fw.rot_x * fw.rot_y;
    q_data.p02 = fw.rot_x * fw.rot_z;
    q_data.p12 = fw.rot_y * fw.rot_z;
  end

endmodule

// ===== sv/rvm_queue.sv =====
module rvm_queue
  import rvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  qe_t  wdata,
  output logic full,
  input  logic rd,
  output qe_t  rdata,
  output logic empty
);

  qe_t            mem [QD];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;
  logic           do_wr;
  logic           do_rd;

  assign full  = cnt == (QAW+1)'(QD);
  assign empty = cnt == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= wp + 1'b1;
      end
      if (do_rd) begin
        rp <= rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule

// ===== sv/rvm_back.sv =====
module rvm_back
  import rvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  qe_t  q_data,
  input  logic q_empty,
  output logic q_pop,
  output out_t mat,
  output logic empty,
  input  logic pop
);

  localparam int ST_SQ0  = 1;
  localparam int ST_SQ1  = 32;
  localparam int ST_MOD  = 33;
  localparam int ST_OCT  = 34;
  localparam int ST_U    = 35;
  localparam int ST_TSQ  = 36;
  localparam int ST_HN0  = 37;
  localparam int ST_HN1  = 42;
  localparam int ST_PST1 = 43;
  localparam int ST_PST2 = 44;
  localparam int ST_DA0  = 45;
  localparam int ST_DA1  = 80;
  localparam int ST_MID  = 81;
  localparam int ST_DB0  = 82;
  localparam int ST_DB1  = 117;
  localparam int ST_FIN1 = 118;
  localparam int ST_FIN2 = 119;
  localparam int ST_LAST = 120;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } sm_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [35:0] low;
    logic [35:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic signed [31:0] w2;
    sm_t                kd0;
    sm_t                kd1;
    sm_t                kd2;
    sm_t                ko01;
    sm_t                ko02;
    sm_t                ko12;
    logic               low_angle;
    logic [29:0]        t_small;
    sqrt_t              sr;
    logic [31:0]        n;
    logic [30:0]        r;
    logic [2:0]         oct;
    logic [27:0]        u;
    logic [29:0]        t;
    logic [34:0]        ps;
    logic [34:0]        pc;
    logic [32:0]        a_pre;
    logic [32:0]        b_pre;
    logic [33:0]        s0;
    logic [33:0]        c0;
    logic               a_neg;
    div_t               da;
    div_t               dx;
    div_t               db;
    logic [32:0]        a_mag;
    logic [32:0]        b_mag;
    logic [8:0][34:0]   ta_mag;
    logic [8:0]         ta_neg;
    logic [8:0][37:0]   tb_mag;
    logic [8:0]         tb_neg;
    out_t               res;
  } ctx_t;

  ctx_t             st [ST_LAST+1];
  logic [ST_LAST:0] vld;
  logic             adv;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : 32'(v);
  endfunction

  function automatic sm_t cross_term(input logic signed [63:0] p);
    logic [63:0] pm;
    logic [63:0] tmp;
    sm_t         o;
    pm    = p[63] ? (~p + 64'd1) : p;
    tmp   = pm + 64'h8000_0000;
    o.neg = p[63];
    o.mag = tmp[63:32];
    return o;
  endfunction

  function automatic sm_t diag_term(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] tmp;
    sm_t         o;
    tmp   = a + b + 64'h8000_0000;
    o.neg = 1'b1;
    o.mag = tmp[63:32];
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t c);
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;
    sqrt_t       o;
    r2     = {c.rem, c.rad[63:62]};
    trial  = {2'b00, c.root, 2'b01};
    ge     = r2 >= trial;
    o.rad  = c.rad << 2;
    o.rem  = ge ? 34'(r2 - trial) : 34'(r2);
    o.root = {c.root[30:0], ge};
    return o;
  endfunction

  function automatic div_t div_init(input logic [63:0] num);
    div_t o;
    o.rem = 32'(num[63:36]);
    o.low = num[35:0];
    o.quo = '0;
    return o;
  endfunction

  function automatic div_t div_step(input div_t c, input logic [31:0] den);
    logic [32:0] r2;
    logic        ge;
    div_t        o;
    r2    = {c.rem, c.low[35]};
    ge    = r2 >= {1'b0, den};
    o.rem = ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
    o.low = c.low << 1;
    o.quo = {c.quo[34:0], ge};
    return o;
  endfunction

  function automatic ctx_t init_fn(input qe_t q);
    logic [63:0] s;
    logic [63:0] tmp;
    ctx_t        o;
    o           = '0;
    s           = q.sq0 + q.sq1 + q.sq2;
    tmp         = s + 64'd33554432;
    o.w0        = q.w0;
    o.w1        = q.w1;
    o.w2        = q.w2;
    o.low_angle = s <= 64'h0040_0000_0000_0000;
    o.t_small   = tmp[55:26];
    o.kd0       = diag_term(q.sq1, q.sq2);
    o.kd1       = diag_term(q.sq0, q.sq2);
    o.kd2       = diag_term(q.sq0, q.sq1);
    o.ko01      = cross_term(q.p01);
    o.ko02      = cross_term(q.p02);
    o.ko12      = cross_term(q.p12);
    o.sr.rad    = s;
    o.sr.rem    = '0;
    o.sr.root   = '0;
    return o;
  endfunction

  function automatic ctx_t step_fn(input int k, input ctx_t c);
    ctx_t               o;
    logic [64:0]        pr;
    logic [64:0]        pr2;
    logic [63:0]        num;
    logic [35:0]        t36;
    logic [34:0]        d;
    logic [34:0]        cf;
    logic [27:0]        f;
    logic [2:0]         hi;
    logic [2:0]         o1;
    logic [2:0]         o2;
    logic [33:0]        sn;
    logic [33:0]        cm;
    logic [33:0]        omc;
    logic [8:0][31:0]   k1m;
    logic [8:0]         k1n;
    logic [8:0][31:0]   kkm;
    logic [8:0]         kkn;
    logic signed [40:0] v;
    logic [8:0][31:0]   rm;
    o = c;
    if (k >= ST_SQ0 && k <= ST_SQ1) begin
      o.sr = sqrt_step(c.sr);
    end else if (k == ST_MOD) begin
      o.n = c.sr.root;
      if (c.sr.root >= M2) begin
        o.r = 31'(c.sr.root - M2);
      end else if (c.sr.root >= M1) begin
        o.r = 31'(c.sr.root - M1);
      end else begin
        o.r = 31'(c.sr.root);
      end
    end else if (k == ST_OCT) begin
      o.oct = '0;
      for (int i = 1; i < 8; i++) begin
        if (c.r >= OCT_BASE[i]) begin
          o.oct = o.oct + 3'd1;
        end
      end
    end else if (k == ST_U) begin
      f   = 28'(c.r - OCT_BASE[c.oct]);
      o.u = c.oct[0] ? (P4 - f) : f;
    end else if (k == ST_TSQ) begin
      pr   = 65'(c.u) * 65'(c.u);
      pr2  = pr + 65'd33554432;
      o.t  = c.low_angle ? c.t_small : pr2[55:26];
      o.ps = SIN_C[6];
      o.pc = OMC_C[6];
    end else if (k >= ST_HN0 && k <= ST_HN1) begin
      // one horner step for each series
      hi   = 3'(ST_HN1 - k);
      pr   = 65'(c.t) * 65'(c.ps);
      pr2  = pr + 65'd536870912;
      d    = pr2[64:30];
      cf   = SIN_C[hi];
      o.ps = (d > cf) ? '0 : cf - d;
      pr   = 65'(c.t) * 65'(c.pc);
      pr2  = pr + 65'd536870912;
      d    = pr2[64:30];
      cf   = OMC_C[hi];
      o.pc = (d > cf) ? '0 : cf - d;
    end else if (k == ST_PST1) begin
      t36     = 36'(c.ps) + 36'd2;
      o.a_pre = t36[34:2];
      t36     = 36'(c.pc) + 36'd2;
      o.b_pre = t36[34:2];
      pr      = 65'(c.u) * 65'(c.ps);
      pr2     = pr + 65'd536870912;
      o.s0    = pr2[63:30];
      pr      = 65'(c.t) * 65'(c.pc);
      pr2     = pr + 65'd2147483648;
      o.c0    = 34'h1_0000_0000 - {1'b0, pr2[64:32]};
    end else if (k == ST_PST2) begin
      // octant symmetries
      o1      = c.oct + 3'd1;
      o2      = c.oct + 3'd2;
      sn      = o1[1] ? c.c0 : c.s0;
      cm      = o1[1] ? c.s0 : c.c0;
      o.a_neg = c.oct[2];
      omc     = o2[2] ? 34'h1_0000_0000 + cm : 34'h1_0000_0000 - cm;
      num     = (64'(sn) << 28) + 64'(c.n >> 1);
      o.da    = div_init(num);
      num     = (64'(omc) << 28) + 64'(c.n >> 1);
      o.dx    = div_init(num);
    end else if (k >= ST_DA0 && k <= ST_DA1) begin
      o.da = div_step(c.da, c.n);
      o.dx = div_step(c.dx, c.n);
    end else if (k == ST_MID) begin
      num  = {c.dx.quo[35:0], 28'd0} + 64'(c.n >> 1);
      o.db = div_init(num);
    end else if (k >= ST_DB0 && k <= ST_DB1) begin
      o.db = div_step(c.db, c.n);
    end else if (k == ST_FIN1) begin
      if (c.low_angle) begin
        o.a_mag = (c.a_pre > 33'h1_0000_0000) ? 33'h1_0000_0000 : c.a_pre;
        o.a_neg = 1'b0;
        o.b_mag = (c.b_pre > 33'h1_0000_0000) ? 33'h1_0000_0000 : c.b_pre;
      end else begin
        o.a_mag = (c.da.quo > 36'h1_0000_0000) ? 33'h1_0000_0000 : 33'(c.da.quo);
        o.b_mag = (c.db.quo > 36'h1_0000_0000) ? 33'h1_0000_0000 : 33'(c.db.quo);
      end
    end else if (k == ST_FIN2) begin
      // skew matrix and its square, row major, entry 0 in the top slot
      k1m[8] = '0;           k1n[8] = 1'b0;
      k1m[7] = mag32(c.w2);  k1n[7] = !c.w2[31];
      k1m[6] = mag32(c.w1);  k1n[6] = c.w1[31];
      k1m[5] = mag32(c.w2);  k1n[5] = c.w2[31];
      k1m[4] = '0;           k1n[4] = 1'b0;
      k1m[3] = mag32(c.w0);  k1n[3] = !c.w0[31];
      k1m[2] = mag32(c.w1);  k1n[2] = !c.w1[31];
      k1m[1] = mag32(c.w0);  k1n[1] = c.w0[31];
      k1m[0] = '0;           k1n[0] = 1'b0;
      kkm[8] = c.kd0.mag;    kkn[8] = c.kd0.neg;
      kkm[7] = c.ko01.mag;   kkn[7] = c.ko01.neg;
      kkm[6] = c.ko02.mag;   kkn[6] = c.ko02.neg;
      kkm[5] = c.ko01.mag;   kkn[5] = c.ko01.neg;
      kkm[4] = c.kd1.mag;    kkn[4] = c.kd1.neg;
      kkm[3] = c.ko12.mag;   kkn[3] = c.ko12.neg;
      kkm[2] = c.ko02.mag;   kkn[2] = c.ko02.neg;
      kkm[1] = c.ko12.mag;   kkn[1] = c.ko12.neg;
      kkm[0] = c.kd2.mag;    kkn[0] = c.kd2.neg;
      for (int e = 0; e < 9; e++) begin
        pr          = 65'(c.a_mag) * 65'(k1m[e]);
        pr2         = pr + 65'd536870912;
        o.ta_mag[e] = pr2[64:30];
        o.ta_neg[e] = c.a_neg ^ k1n[e];
        pr          = 65'(c.b_mag) * 65'(kkm[e]);
        pr2         = pr + 65'd33554432;
        o.tb_mag[e] = pr2[63:26];
        o.tb_neg[e] = kkn[e];
      end
    end else if (k == ST_LAST) begin
      for (int e = 0; e < 9; e++) begin
        v = (e == 0 || e == 4 || e == 8) ? 41'sd1073741824 : 41'sd0;
        if (c.ta_neg[e]) begin
          v = v - $signed({6'b0, c.ta_mag[e]});
        end else begin
          v = v + $signed({6'b0, c.ta_mag[e]});
        end
        if (c.tb_neg[e]) begin
          v = v - $signed({3'b0, c.tb_mag[e]});
        end else begin
          v = v + $signed({3'b0, c.tb_mag[e]});
        end
        if (v > 41'sd1073741824) begin
          v = 41'sd1073741824;
        end else if (v < -41'sd1073741824) begin
          v = -41'sd1073741824;
        end
        rm[e] = 32'(v);
      end
      o.res = out_t'(rm);
    end
    return o;
  endfunction

  // the whole pipe moves together, held only when the result is not taken
  assign adv   = !vld[ST_LAST] || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !vld[ST_LAST];
  assign mat   = st[ST_LAST].res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_LAST-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= init_fn(q_data);
    end
  end

  for (genvar k = 1; k <= ST_LAST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= step_fn(k, st[k-1]);
      end
    end
  end

endmodule

// ===== sv/rotation_vector_to_matrix.sv =====
// Rotation vector to rotation matrix. A rotation vector in Q4.28 radians is
// turned into the nine Q2.30 entries of R = I + a*[w]x + b*[w]x^2, row major.
// One vector can be pushed every clock while full is low and one matrix popped
// every clock while empty is low. A request passes one front register forming
// the squares and cross products, a 4-entry queue, then a 121-stage back
// pipeline set by its 32 square-root stages and two chained 36-stage
// dividers. The front keeps taking requests while a result waits to be popped
// until the queue fills.
module rotation_vector_to_matrix
  import rvm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  vec,
  output logic empty,
  input  logic pop,
  output out_t mat
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  qe_t  q_wdata;
  qe_t  q_rdata;

  rvm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .vec    (vec),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  rvm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  rvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .mat     (mat),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ===== tb/sv/tb_rotation_vector_to_matrix.sv =====
`timescale 1ns / 1ps

module tb_rotation_vector_to_matrix;
  import rvm_pkg::*;

  typedef longint unsigned u64;

  localparam u64 P4_Q28   = 64'd210828714;
  localparam u64 ONE_Q32  = 64'd1 << 32;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam u64 HALF_LIM = 64'd1 << 54;
  localparam int IDLE_LIMIT = 3000;
  localparam int N_RANDOM = 480;

  logic clk, rst, push, full, empty, pop;
  in_t  vec;
  out_t mat;

  int errors = 0;
  int idle_cycles = 0;
  bit sending_done = 0;
  bit hold_pop = 0;

  rotation_vector_to_matrix uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vec(vec),
    .empty(empty), .pop(pop), .mat(mat)
  );

  task automatic report_mismatch(input int idx, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch m%0d%0d: got %0d expected %0d", idx / 3, idx % 3,
             $signed(got), $signed(want));
    errors++;
  endtask

  function automatic u64 rnd(u64 v, int k);
    return (v + (u64'(1) << (k - 1))) >> k;
  endfunction

  function automatic u64 mag(longint v);
    return v < 0 ? u64'(0) - u64'(v) : u64'(v);
  endfunction

  function automatic longint mul_rnd(longint x, longint y, int k);
    u64 m;
    m = rnd(mag(x) * mag(y), k);
    return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // taylor sum in t, sine or one-minus-cosine coefficients
  function automatic u64 series(bit omc, u64 t);
    u64 p, d, c;
    p = omc ? u64'(OMC_C[6]) : u64'(SIN_C[6]);
    for (int k = 5; k >= 0; k--) begin
      c = omc ? u64'(OMC_C[k]) : u64'(SIN_C[k]);
      d = rnd(t * p, 30);
      p = d > c ? 0 : c - d;
    end
    return p;
  endfunction

  function automatic u64 int_sqrt(u64 v);
    u64 r, b;
    r = 0;
    b = u64'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_t rodrigues_matrix(in_t v);
    longint w[3], k1[3][3], k2[3][3], a, b, sn, cs, s0, c0, e;
    u64 sq[3], s, t, n, r, oct, f, u, am, omc, x1;
    bit [287:0] flat;
    w[0] = longint'(v.rot_x);
    w[1] = longint'(v.rot_y);
    w[2] = longint'(v.rot_z);
    for (int i = 0; i < 3; i++) sq[i] = mag(w[i]) * mag(w[i]);
    s = sq[0] + sq[1] + sq[2];
    if (s <= HALF_LIM) begin
      t = rnd(s, 26);
      a = longint'(rnd(series(0, t), 2));
      b = longint'(rnd(series(1, t), 2));
    end else begin
      n = int_sqrt(s);
      r = n % (8 * P4_Q28);
      oct = r / P4_Q28;
      f = r - oct * P4_Q28;
      u = oct[0] ? P4_Q28 - f : f;
      t = rnd(u * u, 26);
      s0 = longint'(rnd(u * series(0, t), 30));
      c0 = longint'(ONE_Q32) - longint'(rnd(t * series(1, t), 32));
      // octant symmetries
      if (((oct + 1) & 2) != 0) begin
        sn = c0; cs = s0;
      end else begin
        sn = s0; cs = c0;
      end
      if (oct[2]) sn = -sn;
      if (((oct + 2) & 4) != 0) cs = -cs;
      am = ((mag(sn) << 28) + n / 2) / n;
      a = sn < 0 ? -longint'(am) : longint'(am);
      omc = u64'(longint'(ONE_Q32) - cs);
      x1 = ((omc << 28) + n / 2) / n;
      b = longint'(((x1 << 28) + n / 2) / n);
    end
    a = clip(a, -longint'(ONE_Q32), longint'(ONE_Q32));
    b = clip(b, 0, longint'(ONE_Q32));
    k1 = '{'{0, -w[2], w[1]}, '{w[2], 0, -w[0]}, '{-w[1], w[0], 0}};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        k2[i][j] = (i == j) ? -longint'(rnd(s - sq[i], 32)) : mul_rnd(w[i], w[j], 32);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = (i == j) ? ONE_Q30 : 0;
        e += mul_rnd(a, k1[i][j], 30) + mul_rnd(b, k2[i][j], 26);
        e = clip(e, -ONE_Q30, ONE_Q30);
        flat[287 - 32 * (3 * i + j) -: 32] = e[31:0];
      end
    return out_t'(flat);
  endfunction

  class matrix_board;
    out_t expected_mats[$];

    function void note_vector(in_t v);
      expected_mats.push_back(rodrigues_matrix(v));
    endfunction

    task check_matrix(out_t got);
      out_t want;
      bit [287:0] g, x;
      if (expected_mats.size() == 0) begin
        $display("matrix popped with none outstanding");
        errors++;
      end else begin
        want = expected_mats.pop_front();
        g = got;
        x = want;
        for (int i = 0; i < 9; i++)
          if (g[287 - 32 * i -: 32] !== x[287 - 32 * i -: 32])
            report_mismatch(i, g[287 - 32 * i -: 32], x[287 - 32 * i -: 32]);
      end
    endtask

    function int pending();
      return expected_mats.size();
    endfunction
  endclass

  matrix_board board = new();

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    return r < 55 ? 0 : (r < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) board.note_vector(vec);
      if (pop && !empty) board.check_matrix(mat);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      push = 0;
      repeat (g) @(negedge clk);
    end
    push = 1;
    vec = '{rot_x: x, rot_y: y, rot_z: z};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp(int kind);
    case (kind)
      0: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      1: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
      2: return 32'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
      default: return $urandom;
    endcase
  endfunction

  // receiver: pops with random stalls, bursts of steady popping
  initial begin
    int g;
    pop = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = hold_pop ? 0 : gap_len();
      if (g > 0) begin
        pop = 0;
        repeat (g) @(negedge clk);
      end
      pop = 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    int kind;
    bit burst;
    logic [31:0] x, y, z;
    rst = 1;
    push = 0;
    vec = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero vector, extremes, small/large boundary, multiples of pi/4
    send_vector(0, 0, 0, 0);
    send_vector(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
    send_vector(32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_vector(32'h80000000, 0, 0, 1);
    send_vector(0, 32'h7fffffff, 0, 1);
    send_vector(0, 0, 32'h80000000, 1);
    send_vector(1, 0, 0, 0);
    send_vector(32'hffffffff, 1, 32'hffffffff, 0);
    send_vector(32'd134217728, 0, 0, 0);
    send_vector(32'd134217729, 0, 0, 0);
    send_vector(0, 32'hf7ffffff, 0, 0);
    send_vector(32'd77497742, 32'd77497742, 32'd77497742, 0);
    send_vector(32'd843314857, 0, 0, 1);
    send_vector(0, 0, 32'd1686629713, 1);
    send_vector(32'd1686629712, 0, 0, 0);
    send_vector(32'd210828714, 0, 0, 0);
    send_vector(0, 32'd632486142, 0, 0);
    send_vector(32'd1264972284, 32'hc0000000, 32'd400000000, 0);
    send_vector(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 0);
    send_vector(32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 0);

    // sender holds off until the pipeline drains
    push = 0;
    while (board.pending() != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      burst = (i / 40) % 3 == 1;
      hold_pop = (i / 60) % 4 == 2;
      kind = $urandom_range(0, 3);
      x = rand_comp(kind);
      y = rand_comp($urandom_range(0, 1) ? kind : $urandom_range(0, 3));
      z = rand_comp(kind);
      send_vector(x, y, z, burst);
    end
    push = 0;
    hold_pop = 1;
    while (board.pending() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rvm_pkg.sv
sv/rvm_front.sv
sv/rvm_queue.sv
sv/rvm_back.sv
sv/rotation_vector_to_matrix.sv
tb/sv/tb_rotation_vector_to_matrix.sv
